// File: sv/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the scan polar-to-Cartesian converter
// Default sizes, fixed-point constants, the arctangent table, register
// indices and the control word that travels down the CORDIC chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spc_pkg;

	// Default sizes for the top-level parameters
	localparam int RANGE_BITS_DEF    = 24;
	localparam int ANGLE_BITS_DEF    = 32;
	localparam int CORDIC_STAGES_DEF = 24;

	// Binary angle width (one turn is 2^32) and guard bits on the coordinates
	localparam int ANGLE_W = 32;
	localparam int GUARD   = 16;

	// Inverse CORDIC gain in Q0.32
	localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MIN   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAX   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_START = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP  = 2'd3;

	// atan(2^-i) in binary angle units, rounded
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// Control word carried alongside each sample through the chain
	typedef struct packed {
		logic       valid;
		logic       pass;
		logic       last;
		logic [1:0] quad;
	} spc_ctrl_t;

endpackage

// File: sv/spc_if.sv
// ----------------------------------------------------------------------------
// spc_if: channel interfaces
// Sample channel into the converter and point channel out of it, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spc_sample_if #(
	parameter int RANGE_BITS = 24
);
	logic                  valid;
	logic                  ready;
	logic [RANGE_BITS-1:0] range_value;
	logic                  last_sample;

	modport source (output valid, output range_value, output last_sample, input ready);
	modport sink   (input valid, input range_value, input last_sample, output ready);
endinterface

interface spc_point_if #(
	parameter int RANGE_BITS = 24
);
	logic                       valid;
	logic                       ready;
	logic signed [RANGE_BITS:0] x_pos;
	logic signed [RANGE_BITS:0] y_pos;
	logic                       point_valid;
	logic                       end_of_cloud;

	modport source (output valid, output x_pos, output y_pos, output point_valid,
		output end_of_cloud, input ready);
	modport sink   (input valid, input x_pos, input y_pos, input point_valid,
		input end_of_cloud, output ready);
endinterface

// File: sv/scan_polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian: laser scan range samples to Cartesian points
// One sample is taken per clock cycle while the point channel keeps up; a
// sample's result passes through a front stage (gain multiply and quadrant
// reduction), one CORDIC cell per stage, a quadrant rotation stage and the
// output register. The whole chain holds while a finished point waits on the
// point channel. Samples strictly inside the range gate give a point; the
// sample flagged last always gives a transaction with end_of_cloud set and
// restarts the running angle at angle_start. Other samples give nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_polar_to_cartesian #(
	parameter int RANGE_BITS    = spc_pkg::RANGE_BITS_DEF,
	parameter int ANGLE_BITS    = spc_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = spc_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [spc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data,
	spc_sample_if.sink                       sample,
	spc_point_if.source                      point
);
	import spc_pkg::*;

	localparam int PROD_W = RANGE_BITS + 32;
	localparam int XY_W   = RANGE_BITS + GUARD + 2;
	localparam int RT_W   = XY_W + 1;
	localparam int RND_W  = RT_W + 1;
	localparam int CRD_W  = RND_W - GUARD;

	localparam logic [ANGLE_W-1:0] ANGLE_KEEP =
		~((ANGLE_W'(1) << (ANGLE_W - ANGLE_BITS)) - ANGLE_W'(1));
	localparam logic [ANGLE_W-1:0] QUAD_BIAS  = 32'h2000_0000;
	localparam logic [PROD_W-1:0]  PROD_HALF  =
		{{(PROD_W - 32 + GUARD){1'b0}}, 1'b1, {(31 - GUARD){1'b0}}};
	localparam logic signed [RND_W-1:0] COORD_HALF =
		{{(RND_W - GUARD){1'b0}}, 1'b1, {(GUARD - 1){1'b0}}};
	localparam logic signed [CRD_W-1:0] SAT_HI =
		{{(CRD_W - RANGE_BITS){1'b0}}, {RANGE_BITS{1'b1}}};
	localparam logic signed [CRD_W-1:0] SAT_LO = ~SAT_HI;

	// Configuration and running angle
	logic [RANGE_BITS-1:0] range_min_q;
	logic [RANGE_BITS-1:0] range_max_q;
	logic [ANGLE_W-1:0]    angle_start_q;
	logic [ANGLE_W-1:0]    angle_step_q;
	logic [ANGLE_W-1:0]    angle_offset_q;

	logic en;
	logic accept;

	// Front stage
	logic [ANGLE_W-1:0]        ang;
	logic [ANGLE_W-1:0]        ang_biased;
	logic [1:0]                quad;
	logic [ANGLE_W-1:0]        resid;
	logic                      pass;
	logic [PROD_W-1:0]         prod;
	spc_ctrl_t                 ctrl_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic signed [ANGLE_W-1:0] z_s1;

	// CORDIC chain taps
	spc_ctrl_t                 ctrl_c [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]    x_c    [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]    y_c    [CORDIC_STAGES+1];
	logic signed [ANGLE_W-1:0] z_c    [CORDIC_STAGES+1];

	// Quadrant rotation stage
	logic signed [RT_W-1:0] x_ext;
	logic signed [RT_W-1:0] y_ext;
	logic signed [RT_W-1:0] x_rot;
	logic signed [RT_W-1:0] y_rot;
	spc_ctrl_t              ctrl_s2;
	logic signed [RT_W-1:0] x_s2;
	logic signed [RT_W-1:0] y_s2;

	// Output register
	logic signed [RANGE_BITS:0] x_fin;
	logic signed [RANGE_BITS:0] y_fin;
	logic                       out_valid_q;
	logic signed [RANGE_BITS:0] x_q;
	logic signed [RANGE_BITS:0] y_q;
	logic                       point_valid_q;
	logic                       end_of_cloud_q;

	// Round off the guard bits and saturate to the output width
	function automatic logic signed [RANGE_BITS:0] finish_coord(
		input logic signed [RT_W-1:0] v
	);
		logic signed [RND_W-1:0] t;
		logic signed [CRD_W-1:0] c;
		t = RND_W'(v) + COORD_HALF;
		c = CRD_W'(t >>> GUARD);
		if (c > SAT_HI) begin
			c = SAT_HI;
		end else if (c < SAT_LO) begin
			c = SAT_LO;
		end
		return c[RANGE_BITS:0];
	endfunction

	// Advance the chain whenever the output register is free or being drained
	assign en           = !out_valid_q || point.ready;
	assign sample.ready = en;
	assign accept       = sample.valid && en;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= '0;
			range_max_q   <= '1;
			angle_start_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RANGE_MIN:   range_min_q   <= cfg_data[RANGE_BITS-1:0];
				REG_RANGE_MAX:   range_max_q   <= cfg_data[RANGE_BITS-1:0];
				REG_ANGLE_START: angle_start_q <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data[ANGLE_W-1:0];
			endcase
		end
	end

	// Step the running angle per transaction, restart after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q <= '0;
		end else if (accept) begin
			angle_offset_q <= sample.last_sample ? '0 : angle_offset_q + angle_step_q;
		end
	end

	// Gate the range, reduce to a quadrant and scale by the inverse gain
	always_comb begin
		ang        = (angle_start_q + angle_offset_q) & ANGLE_KEEP;
		ang_biased = ang + QUAD_BIAS;
		quad       = ang_biased[ANGLE_W-1 -: 2];
		resid      = ang - {quad, {(ANGLE_W - 2){1'b0}}};
		pass       = (range_min_q < sample.range_value) && (sample.range_value < range_max_q);
		prod       = PROD_W'(sample.range_value) * PROD_W'(GAIN_Q32) + PROD_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= sample.valid;
			ctrl_s1.pass  <= pass;
			ctrl_s1.last  <= sample.last_sample;
			ctrl_s1.quad  <= quad;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			z_s1    <= resid;
		end
	end

	// Feed the chain: x starts at the scaled range, y at zero
	assign ctrl_c[0] = ctrl_s1;
	assign x_c[0]    = XY_W'(prod_s1[PROD_W-1:GUARD]);
	assign y_c[0]    = '0;
	assign z_c[0]    = z_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		spc_cordic_cell #(
			.XY_W  (XY_W),
			.SHIFT (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctrl_in  (ctrl_c[i]),
			.x_in     (x_c[i]),
			.y_in     (y_c[i]),
			.z_in     (z_c[i]),
			.ctrl_out (ctrl_c[i+1]),
			.x_out    (x_c[i+1]),
			.y_out    (y_c[i+1]),
			.z_out    (z_c[i+1])
		);
	end

	// Turn the vector back by the quadrant taken off at the front
	always_comb begin
		x_ext = RT_W'(x_c[CORDIC_STAGES]);
		y_ext = RT_W'(y_c[CORDIC_STAGES]);
		unique case (ctrl_c[CORDIC_STAGES].quad)
			2'd0: begin
				x_rot = x_ext;
				y_rot = y_ext;
			end
			2'd1: begin
				x_rot = -y_ext;
				y_rot = x_ext;
			end
			2'd2: begin
				x_rot = -x_ext;
				y_rot = -y_ext;
			end
			2'd3: begin
				x_rot = y_ext;
				y_rot = -x_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_c[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_rot;
			y_s2 <= y_rot;
		end
	end

	// Finish coordinates; a dropped sample shows zeros
	always_comb begin
		if (ctrl_s2.pass) begin
			x_fin = finish_coord(x_s2);
			y_fin = finish_coord(y_s2);
		end else begin
			x_fin = '0;
			y_fin = '0;
		end
	end

	// Hold a result until taken; drop samples that neither pass nor end the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_s2.valid && (ctrl_s2.pass || ctrl_s2.last);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q            <= x_fin;
			y_q            <= y_fin;
			point_valid_q  <= ctrl_s2.pass;
			end_of_cloud_q <= ctrl_s2.last;
		end
	end

	assign point.valid        = out_valid_q;
	assign point.x_pos        = x_q;
	assign point.y_pos        = y_q;
	assign point.point_valid  = point_valid_q;
	assign point.end_of_cloud = end_of_cloud_q;

endmodule

// File: sv/spc_cordic_cell.sv
// ----------------------------------------------------------------------------
// spc_cordic_cell: one rotation step of the CORDIC chain
// Turns the vector by +/- atan(2^-SHIFT) towards a zero residual angle and
// registers the result together with the sample's control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_cordic_cell #(
	parameter int XY_W  = 42,
	parameter int SHIFT = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  spc_pkg::spc_ctrl_t                ctrl_in,
	input  logic signed [XY_W-1:0]            x_in,
	input  logic signed [XY_W-1:0]            y_in,
	input  logic signed [spc_pkg::ANGLE_W-1:0] z_in,
	output spc_pkg::spc_ctrl_t                ctrl_out,
	output logic signed [XY_W-1:0]            x_out,
	output logic signed [XY_W-1:0]            y_out,
	output logic signed [spc_pkg::ANGLE_W-1:0] z_out
);
	import spc_pkg::*;

	localparam logic signed [ANGLE_W-1:0] ATAN = ATAN_TAB[SHIFT];

	logic signed [XY_W-1:0]    dx;
	logic signed [XY_W-1:0]    dy;
	logic signed [XY_W-1:0]    x_nx;
	logic signed [XY_W-1:0]    y_nx;
	logic signed [ANGLE_W-1:0] z_nx;
	spc_ctrl_t                 ctrl_q;
	logic signed [XY_W-1:0]    x_q;
	logic signed [XY_W-1:0]    y_q;
	logic signed [ANGLE_W-1:0] z_q;

	// Rotate in the direction that drives the residual towards zero
	always_comb begin
		dx = y_in >>> SHIFT;
		dy = x_in >>> SHIFT;
		if (!z_in[ANGLE_W-1]) begin
			x_nx = x_in - dx;
			y_nx = y_in + dy;
			z_nx = z_in - ATAN;
		end else begin
			x_nx = x_in + dx;
			y_nx = y_in - dy;
			z_nx = z_in + ATAN;
		end
	end

	// Advance the control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_in;
		end
	end

	// Advance the vector and residual
	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	assign ctrl_out = ctrl_q;
	assign x_out    = x_q;
	assign y_out    = y_q;
	assign z_out    = z_q;

endmodule

// File: sv/spc_checker.sv
// ----------------------------------------------------------------------------
// spc_checker: port-level checks for the scan converter
// Watches the point channel and checks the handshake and the shape of each
// result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_checker #(
	parameter int RANGE_BITS = 24
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [RANGE_BITS:0] x_pos,
	input logic signed [RANGE_BITS:0] y_pos,
	input logic                       point_valid,
	input logic                       end_of_cloud
);

	// A stalled result transaction stays offered
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("point valid dropped while stalled");

	// A stalled result transaction keeps its payload
	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(x_pos) && $stable(y_pos)
			&& $stable(point_valid) && $stable(end_of_cloud))
		else $error("point payload changed while stalled");

	// Every result is either a point or the end-of-cloud marker
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_valid || end_of_cloud)
		else $error("result with neither point nor end of cloud");

	// A marker without a point carries zero coordinates
	a_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> x_pos == '0 && y_pos == '0)
		else $error("dropped sample shows nonzero coordinates");

endmodule

bind scan_polar_to_cartesian spc_checker #(
	.RANGE_BITS (RANGE_BITS)
) u_spc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (point.valid),
	.out_ready    (point.ready),
	.x_pos        (point.x_pos),
	.y_pos        (point.y_pos),
	.point_valid  (point.point_valid),
	.end_of_cloud (point.end_of_cloud)
);

// File: dv/scan_polar_to_cartesian_tb.sv
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_tb: self-checking bench for the scan converter
// Streams laser scans into the sample channel and checks every transaction on
// the point channel against a bit-accurate CORDIC predictor held here. Runs a
// short directed part over gate bounds, quadrants and end-of-cloud handling,
// then random scans under several register settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_polar_to_cartesian_tb;

	import spc_pkg::*;

	localparam int  RNG_W       = 24;
	localparam int  STAGES      = 24;
	localparam int  CHAIN_LAT   = STAGES + 3;
	localparam int  SETTLE      = CHAIN_LAT + 8;
	localparam int  SCAN_PHASES = 8;
	localparam int  PHASE_ITEMS = 160;
	localparam logic [63:0] INV_GAIN = 64'h9B74_EDA8;
	localparam logic [RNG_W-1:0] RNG_TOP = {RNG_W{1'b1}};

	// atan(2^-i) in binary angle units
	localparam longint ATAN_UNITS [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	typedef struct packed {
		logic [RNG_W-1:0] range_value;
		logic             last_sample;
	} scan_sample_t;

	typedef struct packed {
		logic signed [RNG_W:0] x_pos;
		logic signed [RNG_W:0] y_pos;
		logic                  point_valid;
		logic                  end_of_cloud;
	} cloud_point_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	spc_sample_if #(.RANGE_BITS(RNG_W)) sample_ch ();
	spc_point_if  #(.RANGE_BITS(RNG_W)) point_ch ();

	scan_polar_to_cartesian #(
		.RANGE_BITS    (RNG_W),
		.ANGLE_BITS    (32),
		.CORDIC_STAGES (STAGES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.point     (point_ch)
	);

	// Predictor copy of registers and running angle
	logic [RNG_W-1:0] gate_lo;
	logic [RNG_W-1:0] gate_hi;
	logic [31:0]      angle_base;
	logic [31:0]      angle_inc;
	logic [31:0]      angle_acc;

	scan_sample_t sample_backlog [$];
	cloud_point_t expected_points [$];
	scan_sample_t next_sample;
	cloud_point_t pred_point;
	cloud_point_t got_point;
	cloud_point_t want_point;
	logic         sample_taken = 1'b0;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int fail_count = 0;
	int n_samples = 0;
	int n_points = 0;
	int n_clouds = 0;

	// Round off the guard bits and saturate to the output width
	function automatic logic [RNG_W:0] round_coord(longint v);
		longint c;
		longint hi;
		hi = (longint'(1) << RNG_W) - 1;
		c = (v + 32768) >>> 16;
		if (c > hi)
			c = hi;
		if (c < -hi - 1)
			c = -hi - 1;
		return c[RNG_W:0];
	endfunction

	// Quadrant reduction, CORDIC rotation and quadrant restore
	function automatic cloud_point_t polar_to_point(logic [RNG_W-1:0] r, logic [31:0] ang,
		logic last);
		logic [31:0]  q;
		logic [31:0]  resid;
		logic [63:0]  p;
		longint       x;
		longint       y;
		longint       z;
		longint       dx;
		longint       dy;
		longint       xo;
		longint       yo;
		cloud_point_t res;
		q = (ang + 32'h2000_0000) >> 30;
		resid = ang - (q << 30);
		z = $signed(resid);
		p = 64'(r) * INV_GAIN + 64'h8000;
		x = longint'(p >> 16);
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_UNITS[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_UNITS[i];
			end
		end
		case (q[1:0])
			2'd0: begin xo = x;  yo = y;  end
			2'd1: begin xo = -y; yo = x;  end
			2'd2: begin xo = -x; yo = -y; end
			default: begin xo = y; yo = -x; end
		endcase
		res.x_pos = round_coord(xo);
		res.y_pos = round_coord(yo);
		res.point_valid = 1'b1;
		res.end_of_cloud = last;
		return res;
	endfunction

	// Clock
	initial begin
		forever #10 clk = ~clk;
	end

	// Sample driver: hold an offered transaction until taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.range_value <= '0;
			sample_ch.last_sample <= 1'b0;
		end else if (!sample_ch.valid || sample_taken) begin
			if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_sample = sample_backlog.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.range_value <= next_sample.range_value;
				sample_ch.last_sample <= next_sample.last_sample;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Point sink back-pressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_ch.ready <= 1'b0;
		end else begin
			point_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Monitor: predict on each accepted sample, check each accepted point
	always @(posedge clk) begin
		sample_taken <= sample_ch.valid && sample_ch.ready;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			n_samples++;
			if (gate_lo < sample_ch.range_value && sample_ch.range_value < gate_hi) begin
				pred_point = polar_to_point(sample_ch.range_value,
					angle_base + angle_acc, sample_ch.last_sample);
				expected_points = {expected_points, pred_point};
			end else if (sample_ch.last_sample) begin
				pred_point = '{x_pos: '0, y_pos: '0, point_valid: 1'b0,
					end_of_cloud: 1'b1};
				expected_points = {expected_points, pred_point};
			end
			angle_acc <= sample_ch.last_sample ? 32'd0 : angle_acc + angle_inc;
		end
		if (arst_n && point_ch.valid && point_ch.ready) begin
			got_point.x_pos = point_ch.x_pos;
			got_point.y_pos = point_ch.y_pos;
			got_point.point_valid = point_ch.point_valid;
			got_point.end_of_cloud = point_ch.end_of_cloud;
			if (expected_points.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected point x=%0d y=%0d pv=%b eoc=%b", $realtime,
						got_point.x_pos, got_point.y_pos, got_point.point_valid,
						got_point.end_of_cloud);
			end else begin
				want_point = expected_points.pop_front();
				n_points++;
				if (got_point.end_of_cloud === 1'b1)
					n_clouds++;
				if (got_point !== want_point) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: point mismatch exp x=%0d y=%0d pv=%b eoc=%b,",
							$realtime, want_point.x_pos, want_point.y_pos,
							want_point.point_valid, want_point.end_of_cloud,
							" got x=%0d y=%0d pv=%b eoc=%b",
							got_point.x_pos, got_point.y_pos, got_point.point_valid,
							got_point.end_of_cloud);
				end
			end
		end
	end

	// Write one register; only called while the converter is idle
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_RANGE_MIN:   gate_lo = value[RNG_W-1:0];
			REG_RANGE_MAX:   gate_hi = value[RNG_W-1:0];
			REG_ANGLE_START: angle_base = value;
			REG_ANGLE_STEP:  angle_inc = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Range registers get junk in the unused upper bits to check the masking
	task automatic set_scan_regs(logic [RNG_W-1:0] lo, logic [RNG_W-1:0] hi,
		logic [31:0] base, logic [31:0] inc);
		write_reg(REG_RANGE_MIN, {8'($urandom), lo});
		write_reg(REG_RANGE_MAX, {8'($urandom), hi});
		write_reg(REG_ANGLE_START, base);
		write_reg(REG_ANGLE_STEP, inc);
	endtask

	task automatic push_sample(logic [RNG_W-1:0] r, logic last);
		scan_sample_t s;
		s.range_value = r;
		s.last_sample = last;
		sample_backlog = {sample_backlog, s};
	endtask

	// Wait until all samples are taken and all points are back, then settle
	task automatic wait_drained();
		@(posedge clk);
		while (sample_backlog.size() != 0 || sample_ch.valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Range biased towards the gate edges and the field extremes
	function automatic logic [RNG_W-1:0] pick_range();
		case ($urandom_range(11))
			0: return '0;
			1: return RNG_TOP;
			2: return gate_lo;
			3: return gate_hi;
			4: return gate_lo + 1'b1;
			5: return gate_hi - 1'b1;
			6: return RNG_W'($urandom);
			default: begin
				if (gate_lo < gate_hi)
					return RNG_W'($urandom_range(gate_hi, gate_lo));
				return RNG_W'($urandom);
			end
		endcase
	endfunction

	// Mostly whole scans of random length, some stray samples as noise
	task automatic queue_scans(int n_items);
		int queued;
		int len;
		queued = 0;
		while (queued < n_items) begin
			@(posedge clk);
			if ($urandom_range(9) == 0) begin
				push_sample(pick_range(), 1'($urandom));
				queued++;
			end else begin
				len = $urandom_range(40, 1);
				for (int i = 0; i < len; i++)
					push_sample(pick_range(), i == len - 1);
				queued += len;
			end
		end
	endtask

	// Stimulus sequence
	initial begin
		logic [31:0] step;
		logic [31:0] base;
		logic [RNG_W-1:0] lo;
		logic [RNG_W-1:0] hi;
		cfg_wr_en = 1'b0;
		cfg_index = REG_RANGE_MIN;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.range_value = '0;
		sample_ch.last_sample = 1'b0;
		point_ch.ready = 1'b0;
		gate_lo = '0;
		gate_hi = RNG_TOP;
		angle_base = '0;
		angle_inc = '0;
		angle_acc = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: both gate bounds, full scale, passing and dropped last
		@(posedge clk);
		push_sample('0, 1'b0);
		push_sample(24'd1, 1'b0);
		push_sample(RNG_TOP, 1'b0);
		push_sample(RNG_TOP - 1'b1, 1'b0);
		push_sample(24'h80_0000, 1'b1);
		push_sample('0, 1'b1);
		wait_drained();

		// Walk all octants from the most negative start, edges of a near-full-scale gate
		set_scan_regs(24'h00_0100, 24'hFF_FF00, 32'h8000_0000, 32'h2000_0000);
		@(posedge clk);
		push_sample(24'h00_0100, 1'b0);
		push_sample(24'hFF_FF00, 1'b0);
		push_sample(24'h00_0101, 1'b0);
		for (int i = 0; i < 8; i++)
			push_sample(24'hFF_FEFF, 1'b0);
		push_sample(24'h01_2345, 1'b1);
		wait_drained();

		// Inverted and collapsed gates drop everything but the end marker
		set_scan_regs(RNG_TOP, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		@(posedge clk);
		push_sample(24'h40_0000, 1'b0);
		push_sample(RNG_TOP, 1'b0);
		push_sample('0, 1'b1);
		wait_drained();
		set_scan_regs(24'h00_5000, 24'h00_5000, 32'h0, 32'h0);
		@(posedge clk);
		push_sample(24'h00_5000, 1'b0);
		push_sample(24'h00_5000, 1'b1);
		wait_drained();

		// Random scans, one register setting and idling pattern per phase
		for (int k = 0; k < SCAN_PHASES; k++) begin
			case (k % 4)
				0: step = 32'h8000_0000;
				1: step = 32'h7FFF_FFFF;
				2: step = 32'($urandom_range(32'h0100_0000)) - 32'h0080_0000;
				default: step = $urandom;
			endcase
			base = (k == 0) ? 32'h7FFF_FFFF : (k == 4) ? 32'h8000_0000 : $urandom;
			if (k == 0) begin
				lo = '0;
				hi = RNG_TOP;
			end else if (k == 5) begin
				lo = RNG_W'($urandom);
				hi = RNG_W'($urandom);
			end else begin
				lo = RNG_W'($urandom_range(24'hFFFF));
				hi = RNG_W'($urandom_range(RNG_TOP, 24'h80_0000));
			end
			set_scan_regs(lo, hi, base, step);
			case (k % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
				default: begin src_idle_pct = 38; snk_stall_pct = 38; end
			endcase
			queue_scans(PHASE_ITEMS);
			wait_drained();
		end

		if (expected_points.size() != 0) begin
			fail_count++;
			$display("%0d expected points never arrived", expected_points.size());
		end
		$display("Converted %0d samples over %0d register settings:",
			n_samples, SCAN_PHASES + 4,
			" %0d points checked, %0d clouds closed", n_points, n_clouds);
		$display("%0d failures", fail_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: scan_polar_to_cartesian.f
sv/spc_pkg.sv
sv/spc_if.sv
sv/spc_cordic_cell.sv
sv/scan_polar_to_cartesian.sv
sv/spc_checker.sv
dv/scan_polar_to_cartesian_tb.sv
